// ===== sv/crcgc_pkg.sv =====
// Shared types and constants for the serial CRC generate and check core.
`default_nettype none

package crcgc_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_POLY   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEGREE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd2;

	// Register widths and reset values.
	localparam int POLY_W   = 32;
	localparam int DEGREE_W = 6;
	localparam logic [POLY_W-1:0]   POLY_RESET   = 32'h0000_1021;
	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 6'd16;
	localparam logic                MODE_RESET   = 1'b0;

	// Kinds of work passed from the front to the back.
	localparam logic [1:0] KIND_ECHO    = 2'd0;
	localparam logic [1:0] KIND_FLUSH   = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// Control part of one queued request.
	typedef struct packed {
		logic [1:0] kind;
		logic       data_bit;
	} task_ctl_t;

endpackage

`default_nettype wire

// ===== sv/crcgc_front.sv =====
// Front end: configuration registers, request intake and the running remainder.
`default_nettype none

module crcgc_front #(
	parameter int MAX_DEGREE = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [crcgc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [crcgc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              msg_bit,
	input  wire logic                              msg_last,
	output logic                                   push_valid,
	input  wire logic                              push_ready,
	output crcgc_pkg::task_ctl_t                   push_ctl,
	output logic [MAX_DEGREE-1:0]                  push_rem,
	output logic [$clog2(MAX_DEGREE+1)-1:0]        push_deg
);
	import crcgc_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic [POLY_W-1:0]     poly_q;
	logic [DEGREE_W-1:0]   deg_q;
	logic                  mode_q;
	logic [MAX_DEGREE-1:0] rem_q;

	logic [DW-1:0]         deg_eff;
	logic [MAX_DEGREE-1:0] mask;
	logic [MAX_DEGREE-1:0] poly_m;
	logic [MAX_DEGREE-1:0] cur;
	logic [MAX_DEGREE-1:0] shifted;
	logic [MAX_DEGREE-1:0] next_rem;
	logic                  top;
	logic                  fb;
	logic                  accept;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			deg_q  <= DEGREE_RESET;
			mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLY:   poly_q <= cfg_wdata[POLY_W-1:0];
				REG_DEGREE: deg_q  <= cfg_wdata[DEGREE_W-1:0];
				REG_MODE:   mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamp the degree into the supported range and build the degree mask.
	always_comb begin
		if (deg_q == '0) begin
			deg_eff = DW'(1);
		end else if (int'(deg_q) > MAX_DEGREE) begin
			deg_eff = DW'(MAX_DEGREE);
		end else begin
			deg_eff = DW'(deg_q);
		end
		for (int i = 0; i < MAX_DEGREE; i++) begin
			mask[i] = (i < int'(deg_eff));
		end
	end

	// One division step. Check mode shifts the bit in; generate mode feeds it back.
	always_comb begin
		poly_m   = MAX_DEGREE'(poly_q) & mask;
		cur      = rem_q & mask;
		top      = cur[IW'(deg_eff - DW'(1))];
		shifted  = (cur << 1) | MAX_DEGREE'(mode_q & msg_bit);
		fb       = mode_q ? top : (top ^ msg_bit);
		next_rem = (shifted & mask) ^ (fb ? poly_m : '0);
	end

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Every generate bit and the last check bit produce a request for the back end.
	always_comb begin
		push_valid = accept && !(mode_q && !msg_last);
		push_rem   = next_rem;
		push_deg   = deg_eff;
		if (mode_q) begin
			push_ctl.kind     = KIND_VERDICT;
			push_ctl.data_bit = |next_rem;
		end else begin
			push_ctl.kind     = msg_last ? KIND_FLUSH : KIND_ECHO;
			push_ctl.data_bit = msg_bit;
		end
	end

	// Running remainder, cleared at the end of each message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= msg_last ? '0 : next_rem;
		end
	end

endmodule

`default_nettype wire

// ===== sv/crcgc_queue.sv =====
// Small request queue that decouples the front end from the back end.
`default_nettype none

module crcgc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (int'(count_q) < DEPTH);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/crcgc_back.sv =====
// Back end: turns queued requests into result items and streams the check bits.
`default_nettype none

module crcgc_back #(
	parameter int MAX_DEGREE = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pop_valid,
	output logic                                   pop_ready,
	input  wire crcgc_pkg::task_ctl_t              pop_ctl,
	input  wire logic [MAX_DEGREE-1:0]             pop_rem,
	input  wire logic [$clog2(MAX_DEGREE+1)-1:0]   pop_deg,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   code_bit,
	output logic                                   is_check_bit,
	output logic                                   error_found,
	output logic                                   out_last
);
	import crcgc_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic                  out_valid_q;
	logic                  code_q;
	logic                  chk_q;
	logic                  err_q;
	logic                  last_q;
	logic [DW-1:0]         cnt_q;
	logic [MAX_DEGREE-1:0] rem_q;
	logic                  take;

	// The output register can load when empty or when its item leaves.
	assign take      = !out_valid_q || out_ready;
	assign pop_ready = take && (cnt_q == '0);

	// Check-bit counter and remainder held for the tail of a codeword.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - DW'(1);
			end else if (pop_valid && pop_ctl.kind == KIND_FLUSH) begin
				cnt_q <= pop_deg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && cnt_q == '0 && pop_valid && pop_ctl.kind == KIND_FLUSH) begin
			rem_q <= pop_rem;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= (cnt_q != '0) || pop_valid;
		end
	end

	// Output payload: a check bit, most significant first, or the queued request.
	always_ff @(posedge clk) begin
		if (take) begin
			if (cnt_q != '0) begin
				code_q <= rem_q[IW'(cnt_q - DW'(1))];
				chk_q  <= 1'b1;
				err_q  <= 1'b0;
				last_q <= (cnt_q == DW'(1));
			end else begin
				unique case (pop_ctl.kind)
					KIND_VERDICT: begin
						code_q <= 1'b0;
						chk_q  <= 1'b0;
						err_q  <= pop_ctl.data_bit;
						last_q <= 1'b1;
					end
					default: begin
						code_q <= pop_ctl.data_bit;
						chk_q  <= 1'b0;
						err_q  <= 1'b0;
						last_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign code_bit     = code_q;
	assign is_check_bit = chk_q;
	assign error_found  = err_q;
	assign out_last     = last_q;

endmodule

`default_nettype wire

// ===== sv/crc_generate_and_check_core.sv =====
// Top level of the bit-serial CRC generator and checker.
//
// Usage: message bits enter one per request on the input channel
// (msg_bit, msg_last). With the mode register at 0 each bit comes back as a
// codeword bit, and after the last bit the remainder follows as degree
// check bits, most significant first, the final one marked by out_last.
// With the mode register at 1 bits are absorbed and the last bit yields one
// verdict request with out_last set; error_found flags a nonzero remainder.
// A result passes through the request queue and then the output register
// before it is presented.
// Throughput: one input bit per cycle while the queue has room; the front
// end does one XOR-shift of the remainder per bit. A generate message's
// last bit occupies the output for itself and its degree check bits, during
// which the two-entry request queue fills and the input channel stalls.
// Reset clears the remainder, the queue and the output register and
// loads the registers with polynomial 0x1021, degree 16, generate mode.
// When the receiver stalls, the output register holds its request and
// the queue absorbs up to two more requests before in_ready drops.
// Configuration is written through cfg_we, cfg_index and cfg_wdata.
`default_nettype none

module crc_generate_and_check_core #(
	parameter int MAX_DEGREE = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [crcgc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [crcgc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              msg_bit,
	input  wire logic                              msg_last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   code_bit,
	output logic                                   is_check_bit,
	output logic                                   error_found,
	output logic                                   out_last
);
	import crcgc_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int QW = $bits(task_ctl_t) + MAX_DEGREE + DW;

	logic                  push_valid;
	logic                  push_ready;
	task_ctl_t             push_ctl;
	logic [MAX_DEGREE-1:0] push_rem;
	logic [DW-1:0]         push_deg;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [QW-1:0]         pop_data;
	task_ctl_t             pop_ctl;
	logic [MAX_DEGREE-1:0] pop_rem;
	logic [DW-1:0]         pop_deg;

	// Intake and remainder update.
	crcgc_front #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.msg_bit   (msg_bit),
		.msg_last  (msg_last),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_ctl  (push_ctl),
		.push_rem  (push_rem),
		.push_deg  (push_deg)
	);

	// Request queue between the two halves.
	crcgc_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_ctl, push_rem, push_deg}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign {pop_ctl, pop_rem, pop_deg} = pop_data;

	// Result sequencing.
	crcgc_back #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_ctl     (pop_ctl),
		.pop_rem     (pop_rem),
		.pop_deg     (pop_deg),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_bit    (code_bit),
		.is_check_bit(is_check_bit),
		.error_found (error_found),
		.out_last    (out_last)
	);

endmodule

`default_nettype wire

// ===== sv/crcgc_checker.sv =====
// Port-level checker for the CRC core, attached to the top level by bind.
`default_nettype none

module crcgc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic code_bit,
	input wire logic is_check_bit,
	input wire logic error_found,
	input wire logic out_last
);

	// A stalled result request stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	// A verdict that flags an error carries no codeword bit and always ends its message.
	a_verdict_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_found |-> out_last && !code_bit && !is_check_bit)
		else $error("malformed verdict request");

	// Check bits stream without gaps until the last one.
	a_check_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && is_check_bit && !out_last |=> out_valid && is_check_bit)
		else $error("gap or break in check bit stream");

	// Out of reset no result is shown.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid right after reset");

endmodule

bind crc_generate_and_check_core crcgc_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.code_bit    (code_bit),
	.is_check_bit(is_check_bit),
	.error_found (error_found),
	.out_last    (out_last)
);

`default_nettype wire
